### rtl/xalu_pkg.sv
// Shared types, opcodes and width helpers for the integer ALU.
`timescale 1ns / 1ps
package xalu_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int MAX_WSEL  = $clog2(MAX_WIDTH / 8);
  localparam int DIV_STEPS = 64;
  localparam int QDEPTH    = 4;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_XADD  = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_CMP   = 4'd3;
  localparam logic [3:0] OP_INC   = 4'd4;
  localparam logic [3:0] OP_DEC   = 4'd5;
  localparam logic [3:0] OP_NEG   = 4'd6;
  localparam logic [3:0] OP_MUL   = 4'd7;
  localparam logic [3:0] OP_IMULW = 4'd8;
  localparam logic [3:0] OP_IMULT = 4'd9;
  localparam logic [3:0] OP_MULX  = 4'd10;
  localparam logic [3:0] OP_DIV   = 4'd11;
  localparam logic [3:0] OP_IDIV  = 4'd12;

  localparam logic [5:0] FL_CF = 6'h01;
  localparam logic [5:0] FL_PF = 6'h02;
  localparam logic [5:0] FL_AF = 6'h04;
  localparam logic [5:0] FL_ZF = 6'h08;
  localparam logic [5:0] FL_SF = 6'h10;
  localparam logic [5:0] FL_OF = 6'h20;

  localparam logic [1:0] WS_8  = 2'd0;
  localparam logic [1:0] WS_16 = 2'd1;
  localparam logic [1:0] WS_32 = 2'd2;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [1:0]  width_sel;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [63:0] operand_hi;
  } in_t;

  typedef struct packed {
    logic [63:0] result_lo;
    logic [63:0] result_hi;
    logic [5:0]  flags;
    logic [5:0]  flag_mask;
    logic        write_dest;
    logic        divide_error;
  } out_t;

  // Decoded beat handed from the front to the back.
  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  ws;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] dh;
    logic [63:0] dl;
    logic [63:0] dv;
    logic        nneg;
    logic        dneg;
    logic        dz;
  } dec_t;

  function automatic logic [63:0] wmask(input logic [1:0] ws);
    case (ws)
      WS_8:    wmask = 64'h0000_0000_0000_00FF;
      WS_16:   wmask = 64'h0000_0000_0000_FFFF;
      WS_32:   wmask = 64'h0000_0000_FFFF_FFFF;
      default: wmask = '1;
    endcase
  endfunction

  function automatic logic msb(input logic [63:0] v, input logic [1:0] ws);
    case (ws)
      WS_8:    msb = v[7];
      WS_16:   msb = v[15];
      WS_32:   msb = v[31];
      default: msb = v[63];
    endcase
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] ws);
    case (ws)
      WS_8:    sext = {{56{v[7]}}, v[7:0]};
      WS_16:   sext = {{48{v[15]}}, v[15:0]};
      WS_32:   sext = {{32{v[31]}}, v[31:0]};
      default: sext = v;
    endcase
  endfunction

  // PF, ZF and SF of a masked result.
  function automatic logic [5:0] res_flags(input logic [63:0] r, input logic [1:0] ws);
    res_flags = '0;
    if (~^r[7:0]) res_flags = res_flags | FL_PF;
    if (r == 64'd0) res_flags = res_flags | FL_ZF;
    if (msb(r, ws)) res_flags = res_flags | FL_SF;
  endfunction

endpackage

### rtl/xalu_front.sv
// Front end: width clamp, operand masking and per-class operand preparation.
`timescale 1ns / 1ps
module xalu_front (
  input  xalu_pkg::in_t  in_beat,
  output xalu_pkg::dec_t dec
);

  logic [1:0]   ws;
  logic [63:0]  m;
  logic [63:0]  a;
  logic [63:0]  b;
  logic [63:0]  h;
  logic         is_idiv;
  logic         is_imul;
  logic [127:0] num;
  logic [127:0] fill;
  logic [63:0]  dvs;

  always_comb begin
    ws = (in_beat.width_sel > 2'(xalu_pkg::MAX_WSEL)) ? 2'(xalu_pkg::MAX_WSEL)
                                                       : in_beat.width_sel;
    m  = xalu_pkg::wmask(ws);
    a  = in_beat.operand_a & m;
    b  = in_beat.operand_b & m;
    h  = in_beat.operand_hi & m;
    is_idiv = (in_beat.opcode == xalu_pkg::OP_IDIV);
    is_imul = (in_beat.opcode == xalu_pkg::OP_IMULW) || (in_beat.opcode == xalu_pkg::OP_IMULT);

    dec.op = in_beat.opcode;
    dec.ws = ws;
    dec.a  = a;
    dec.b  = ((in_beat.opcode == xalu_pkg::OP_INC) || (in_beat.opcode == xalu_pkg::OP_DEC))
             ? 64'd1 : b;
    dec.ma = is_imul ? xalu_pkg::sext(a, ws) : a;
    dec.mb = is_imul ? xalu_pkg::sext(b, ws) : b;

    // 2W-bit dividend, sign-extended and made positive for idiv
    num  = ({64'd0, h} << (8'd8 << ws)) | {64'd0, a};
    fill = ~128'd0 << (8'd16 << ws);
    dec.nneg = is_idiv && xalu_pkg::msb(h, ws);
    if (dec.nneg) num = ~(num | fill) + 128'd1;
    dec.dh = num[127:64];
    dec.dl = num[63:0];

    dvs = is_idiv ? xalu_pkg::sext(b, ws) : b;
    dec.dneg = is_idiv && dvs[63];
    dec.dv = dec.dneg ? (64'd0 - dvs) : dvs;
    dec.dz = (dec.dv == 64'd0);
  end

endmodule

### rtl/xalu_queue.sv
// Short decoded-beat queue between front and back.
`timescale 1ns / 1ps
module xalu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xalu_pkg::dec_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output xalu_pkg::dec_t rdata
);

  localparam int AW = $clog2(xalu_pkg::QDEPTH);

  xalu_pkg::dec_t mem_r [xalu_pkg::QDEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(xalu_pkg::QDEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

### rtl/xalu_back.sv
// Back end: execution pipeline (simple ALU, split multiplier, radix-2 divider).
`timescale 1ns / 1ps
module xalu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  xalu_pkg::dec_t q_data,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output xalu_pkg::out_t out_data
);

  localparam int NST = xalu_pkg::DIV_STEPS;

  logic                 v_r   [NST];
  logic [3:0]           op_r  [NST];
  logic [1:0]           ws_r  [NST];
  xalu_pkg::out_t       res_r [NST];
  logic [63:0]          dr_r  [NST];
  logic [63:0]          dq_r  [NST];
  logic [63:0]          dd_r  [NST];
  logic                 nneg_r[NST];
  logic                 dneg_r[NST];
  logic                 bad_r [NST];

  // multiplier stages
  logic [63:0]  pp_r [4];
  logic [63:0]  sa0_r, sb0_r, sa1_r, sb1_r;
  logic [127:0] full_r;
  logic [63:0]  ph_r, pl_r;

  logic           adv;
  logic           ofull;
  logic           mul_at2;
  xalu_pkg::out_t simple_res, mul_res, fin_res;
  logic [127:0]   full_nxt;
  logic [63:0]    ph_nxt;

  assign adv   = !v_r[NST-1] || !ofull;
  assign q_pop = adv && q_valid;

  // multiply result is ready at stage 2 and replaces the slot entering stage 3
  assign mul_at2 = (op_r[2] == xalu_pkg::OP_MUL) || (op_r[2] == xalu_pkg::OP_IMULW)
                || (op_r[2] == xalu_pkg::OP_IMULT) || (op_r[2] == xalu_pkg::OP_MULX);

  function automatic logic [127:0] div_step(input logic [63:0] r, input logic [63:0] q,
                                            input logic [63:0] d);
    logic [64:0] t;
    logic        ge;
    t  = {r, q[63]};
    ge = (t >= {1'b0, d});
    if (ge) t = t - {1'b0, d};
    div_step = {t[63:0], q[62:0], ge};
  endfunction

  // add / sub / neg family
  always_comb begin
    logic [63:0] m, a, b, r;
    m = xalu_pkg::wmask(q_data.ws);
    a = q_data.a;
    b = q_data.b;
    r = '0;
    simple_res = '0;
    case (q_data.op) inside
      xalu_pkg::OP_ADD, xalu_pkg::OP_XADD, xalu_pkg::OP_INC: begin
        r = (a + b) & m;
        simple_res.flags = xalu_pkg::res_flags(r, q_data.ws);
        if (((a ^ b ^ r) & 64'h10) != 64'd0) simple_res.flags |= xalu_pkg::FL_AF;
        if (xalu_pkg::msb((a ^ r) & (b ^ r), q_data.ws)) simple_res.flags |= xalu_pkg::FL_OF;
        if ((q_data.op != xalu_pkg::OP_INC) && (r < a)) simple_res.flags |= xalu_pkg::FL_CF;
        simple_res.flag_mask  = (q_data.op == xalu_pkg::OP_INC) ? 6'h3E : 6'h3F;
        simple_res.result_lo  = r;
        simple_res.result_hi  = (q_data.op == xalu_pkg::OP_XADD) ? a : 64'd0;
        simple_res.write_dest = 1'b1;
      end
      xalu_pkg::OP_SUB, xalu_pkg::OP_CMP, xalu_pkg::OP_DEC: begin
        r = (a - b) & m;
        simple_res.flags = xalu_pkg::res_flags(r, q_data.ws);
        if (((a ^ b ^ r) & 64'h10) != 64'd0) simple_res.flags |= xalu_pkg::FL_AF;
        if (xalu_pkg::msb((a ^ b) & (a ^ r), q_data.ws)) simple_res.flags |= xalu_pkg::FL_OF;
        if ((q_data.op != xalu_pkg::OP_DEC) && (a < b)) simple_res.flags |= xalu_pkg::FL_CF;
        simple_res.flag_mask  = (q_data.op == xalu_pkg::OP_DEC) ? 6'h3E : 6'h3F;
        simple_res.result_lo  = r;
        simple_res.write_dest = (q_data.op != xalu_pkg::OP_CMP);
      end
      xalu_pkg::OP_NEG: begin
        r = (64'd0 - a) & m;
        simple_res.flags = xalu_pkg::res_flags(r, q_data.ws);
        if (((a ^ r) & 64'h10) != 64'd0) simple_res.flags |= xalu_pkg::FL_AF;
        if (xalu_pkg::msb(a & r, q_data.ws)) simple_res.flags |= xalu_pkg::FL_OF;
        if (a != 64'd0) simple_res.flags |= xalu_pkg::FL_CF;
        simple_res.flag_mask  = 6'h3F;
        simple_res.result_lo  = r;
        simple_res.write_dest = 1'b1;
      end
      default: simple_res = '0;
    endcase
  end

  // multiplier: partial products -> sum -> signed fix -> flags
  always_comb begin
    logic [63:0] fix;
    full_nxt = {64'd0, pp_r[0]} + {32'd0, pp_r[1], 32'd0} + {32'd0, pp_r[2], 32'd0}
             + {pp_r[3], 64'd0};
    fix = 64'd0;
    if ((op_r[1] == xalu_pkg::OP_IMULW) || (op_r[1] == xalu_pkg::OP_IMULT)) begin
      fix = (sa1_r[63] ? sb1_r : 64'd0) + (sb1_r[63] ? sa1_r : 64'd0);
    end
    ph_nxt = full_r[127:64] - fix;
  end

  always_comb begin
    logic [63:0] m, hiw, sl;
    logic [1:0]  ws;
    ws = ws_r[2];
    m  = xalu_pkg::wmask(ws);
    case (ws)
      xalu_pkg::WS_8:  hiw = {56'd0, pl_r[15:8]};
      xalu_pkg::WS_16: hiw = {48'd0, pl_r[31:16]};
      xalu_pkg::WS_32: hiw = {32'd0, pl_r[63:32]};
      default:         hiw = ph_r;
    endcase
    sl = xalu_pkg::sext(pl_r, ws);
    mul_res = '0;
    mul_res.result_lo  = pl_r & m;
    mul_res.result_hi  = hiw;
    mul_res.write_dest = 1'b1;
    case (op_r[2])
      xalu_pkg::OP_MUL: begin
        mul_res.flag_mask = xalu_pkg::FL_CF | xalu_pkg::FL_OF;
        if (hiw != 64'd0) mul_res.flags = xalu_pkg::FL_CF | xalu_pkg::FL_OF;
      end
      xalu_pkg::OP_IMULW, xalu_pkg::OP_IMULT: begin
        mul_res.flag_mask = xalu_pkg::FL_CF | xalu_pkg::FL_OF;
        if ((sl != pl_r) || (ph_r != {64{sl[63]}}))
          mul_res.flags = xalu_pkg::FL_CF | xalu_pkg::FL_OF;
        if (op_r[2] == xalu_pkg::OP_IMULT) mul_res.result_hi = 64'd0;
      end
      default: ;
    endcase
  end

  // divider wrap-up at the last stage
  always_comb begin
    logic [63:0] m, q, rm, lim;
    logic [1:0]  ws;
    logic        sgn, ok, is_div;
    ws  = ws_r[NST-1];
    m   = xalu_pkg::wmask(ws);
    q   = dq_r[NST-1];
    rm  = dr_r[NST-1];
    lim = 64'd1 << ((8'd8 << ws) - 8'd1);
    sgn = nneg_r[NST-1] ^ dneg_r[NST-1];
    is_div = (op_r[NST-1] == xalu_pkg::OP_DIV) || (op_r[NST-1] == xalu_pkg::OP_IDIV);
    if (op_r[NST-1] == xalu_pkg::OP_DIV) begin
      ok = !bad_r[NST-1] && (q <= m);
    end else begin
      ok = !bad_r[NST-1] && (sgn ? (q <= lim) : (q < lim));
      if (sgn) q = 64'd0 - q;
      if (nneg_r[NST-1]) rm = 64'd0 - rm;
    end
    fin_res = res_r[NST-1];
    if (is_div) begin
      fin_res = '0;
      if (ok) begin
        fin_res.result_lo  = q & m;
        fin_res.result_hi  = rm & m;
        fin_res.write_dest = 1'b1;
      end else begin
        fin_res.divide_error = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_valid;
      for (int k = 1; k < NST; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r[0]   <= q_data.op;
      ws_r[0]   <= q_data.ws;
      res_r[0]  <= simple_res;
      {dr_r[0], dq_r[0]} <= div_step(q_data.dh, q_data.dl, q_data.dv);
      dd_r[0]   <= q_data.dv;
      nneg_r[0] <= q_data.nneg;
      dneg_r[0] <= q_data.dneg;
      // quotient must fit 64 bits: high part below divisor
      bad_r[0]  <= q_data.dz || (q_data.dh >= q_data.dv);
      for (int k = 1; k < NST; k++) begin
        op_r[k]   <= op_r[k-1];
        ws_r[k]   <= ws_r[k-1];
        res_r[k]  <= ((k == 3) && mul_at2) ? mul_res : res_r[k-1];
        {dr_r[k], dq_r[k]} <= div_step(dr_r[k-1], dq_r[k-1], dd_r[k-1]);
        dd_r[k]   <= dd_r[k-1];
        nneg_r[k] <= nneg_r[k-1];
        dneg_r[k] <= dneg_r[k-1];
        bad_r[k]  <= bad_r[k-1];
      end

      pp_r[0] <= {32'd0, q_data.ma[31:0]}  * {32'd0, q_data.mb[31:0]};
      pp_r[1] <= {32'd0, q_data.ma[31:0]}  * {32'd0, q_data.mb[63:32]};
      pp_r[2] <= {32'd0, q_data.ma[63:32]} * {32'd0, q_data.mb[31:0]};
      pp_r[3] <= {32'd0, q_data.ma[63:32]} * {32'd0, q_data.mb[63:32]};
      sa0_r   <= q_data.ma;
      sb0_r   <= q_data.mb;
      full_r  <= full_nxt;
      sa1_r   <= sa0_r;
      sb1_r   <= sb0_r;
      ph_r    <= ph_nxt;
      pl_r    <= full_r[63:0];
    end
  end

  // two-entry result buffer
  xalu_pkg::out_t ob_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           o_push, o_pop;

  assign ofull     = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_data  = ob_r[rp_r];
  assign o_push    = v_r[NST-1] && !ofull;
  assign o_pop     = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (o_push) wp_r <= ~wp_r;
      if (o_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(o_push) - 2'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) ob_r[wp_r] <= fin_res;
  end

endmodule

### rtl/x86_integer_alu.sv
// Top level of the x86 integer ALU with flags.
// Every op takes the queue, the same 64-stage divider pipeline depth and
// the result buffer to out_*. Throughput: one beat per cycle, set by
// the one-step-per-stage divider, while the result buffer has room.
// Reset: synchronous active-low rst_n empties both queues and the pipe.
`timescale 1ns / 1ps
module x86_integer_alu (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  xalu_pkg::in_t  in_data,
  output logic           in_full,
  output logic           out_empty,
  input  logic           out_pop,
  output xalu_pkg::out_t out_data
);

  // front: decode and operand prep, written straight into the queue
  xalu_pkg::dec_t dec;
  xalu_pkg::dec_t q_data;
  logic           q_valid;
  logic           q_pop;

  xalu_front u_front (
    .in_beat (in_data),
    .dec     (dec)
  );

  // short queue: lets the back stall on a full result buffer while the
  // front keeps taking beats
  xalu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (dec),
    .full  (in_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_data)
  );

  // back: execution pipe plus a two-entry result buffer
  xalu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

### rtl/xalu_checker.sv
// Port-level checks for the integer ALU, bound to the top level.
`timescale 1ns / 1ps
module xalu_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_empty,
  input logic           out_pop,
  input xalu_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_div_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.divide_error) |->
      (!out_data.write_dest && out_data.flag_mask == 6'd0 && out_data.result_lo == 64'd0))
    else $error("divide error beat writes state");

  a_flags_masked: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_data.flags & ~out_data.flag_mask) == 6'd0))
    else $error("flag set outside mask");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind x86_integer_alu xalu_checker u_chk (.*);

### test/x86_integer_alu_tb.sv
// Self-checking testbench for the x86 integer ALU: directed and random beats checked in order.
`timescale 1ns / 1ps
module x86_integer_alu_tb;
  import xalu_pkg::*;

  // Expected-result store: one entry per accepted input beat, checked in order.
  class alu_scoreboard;
    out_t pending[$];
    int   n_fail;
    int   n_checked;

    function void note_input(input out_t exp_res);
      pending.push_back(exp_res);
    endfunction

    function void check_result(input out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat %p", got);
        n_fail++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (got.result_lo !== e.result_lo) begin
        $error("result_lo exp %h got %h", e.result_lo, got.result_lo); n_fail++;
      end
      if (got.result_hi !== e.result_hi) begin
        $error("result_hi exp %h got %h", e.result_hi, got.result_hi); n_fail++;
      end
      if (got.flags !== e.flags) begin
        $error("flags exp %h got %h", e.flags, got.flags); n_fail++;
      end
      if (got.flag_mask !== e.flag_mask) begin
        $error("flag_mask exp %h got %h", e.flag_mask, got.flag_mask); n_fail++;
      end
      if (got.write_dest !== e.write_dest) begin
        $error("write_dest exp %b got %b", e.write_dest, got.write_dest); n_fail++;
      end
      if (got.divide_error !== e.divide_error) begin
        $error("divide_error exp %b got %b", e.divide_error, got.divide_error); n_fail++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_t  in_data = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_t out_data;

  alu_scoreboard sb = new();
  bit   sending_done = 1'b0;
  int   n_sent = 0;
  int   op_seen[16];

  always #2 clk = ~clk;

  x86_integer_alu i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  // ---------------- prediction ----------------
  function automatic logic [5:0] szp_flags(input logic [63:0] r, input int w);
    logic [5:0] f;
    f = '0;
    if (~^r[7:0]) f |= FL_PF;
    if (r == 0) f |= FL_ZF;
    if (r[w-1]) f |= FL_SF;
    return f;
  endfunction

  function automatic logic [63:0] to_width(input logic [63:0] v, input int w);
    return (w >= 64) ? v : (v & ((64'd1 << w) - 1));
  endfunction

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input int w);
    logic [63:0] t;
    t = to_width(v, w);
    if (w < 64 && t[w-1]) t |= ~((64'd1 << w) - 1);
    return t;
  endfunction

  // Full x86 semantics of one beat, using 128-bit arithmetic directly.
  function automatic out_t alu_predict(input in_t x);
    out_t        o;
    int          w;
    logic [63:0] a, b, h, r, m;
    logic [63:0] sa, sb, sl;
    logic [127:0] p, n, q, rm, dv;
    logic signed [127:0] sp;
    logic        nneg, dneg, ok;
    o = '0;
    w = 8 << x.width_sel;
    m = to_width('1, w);
    a = x.operand_a & m;
    b = x.operand_b & m;
    h = x.operand_hi & m;
    case (x.opcode)
      OP_ADD, OP_XADD, OP_INC: begin
        if (x.opcode == OP_INC) b = 64'd1;
        r = (a + b) & m;
        o.flags = szp_flags(r, w);
        if ((a ^ b ^ r) & 64'h10) o.flags |= FL_AF;
        if ((((a ^ r) & (b ^ r)) >> (w - 1)) & 1) o.flags |= FL_OF;
        if (x.opcode != OP_INC && r < a) o.flags |= FL_CF;
        o.flag_mask = (x.opcode == OP_INC) ? 6'h3E : 6'h3F;
        o.result_lo = r;
        o.result_hi = (x.opcode == OP_XADD) ? a : '0;
        o.write_dest = 1'b1;
      end
      OP_SUB, OP_CMP, OP_DEC: begin
        if (x.opcode == OP_DEC) b = 64'd1;
        r = (a - b) & m;
        o.flags = szp_flags(r, w);
        if ((a ^ b ^ r) & 64'h10) o.flags |= FL_AF;
        if ((((a ^ b) & (a ^ r)) >> (w - 1)) & 1) o.flags |= FL_OF;
        if (x.opcode != OP_DEC && a < b) o.flags |= FL_CF;
        o.flag_mask = (x.opcode == OP_DEC) ? 6'h3E : 6'h3F;
        o.result_lo = r;
        o.write_dest = (x.opcode != OP_CMP);
      end
      OP_NEG: begin
        r = (64'd0 - a) & m;
        o.flags = szp_flags(r, w);
        if ((a ^ r) & 64'h10) o.flags |= FL_AF;
        if (((a & r) >> (w - 1)) & 1) o.flags |= FL_OF;
        if (a != 0) o.flags |= FL_CF;
        o.flag_mask = 6'h3F;
        o.result_lo = r;
        o.write_dest = 1'b1;
      end
      OP_MUL, OP_MULX: begin
        p = {64'd0, a} * {64'd0, b};
        o.result_lo = p[63:0] & m;
        o.result_hi = (p >> w) & m;
        if (x.opcode == OP_MUL) begin
          if (o.result_hi != 0) o.flags = FL_CF | FL_OF;
          o.flag_mask = FL_CF | FL_OF;
        end
        o.write_dest = 1'b1;
      end
      OP_IMULW, OP_IMULT: begin
        sa = sign_ext(a, w);
        sb = sign_ext(b, w);
        sp = $signed({{64{sa[63]}}, sa}) * $signed({{64{sb[63]}}, sb});
        o.result_lo = sp[63:0] & m;
        o.result_hi = (x.opcode == OP_IMULW) ? (sp >> w) & m : '0;
        // overflow when the product does not survive truncation to w bits
        sl = sign_ext(sp[63:0], w);
        if ({{64{sl[63]}}, sl} != sp)
          o.flags = FL_CF | FL_OF;
        o.flag_mask = FL_CF | FL_OF;
        o.write_dest = 1'b1;
      end
      OP_DIV, OP_IDIV: begin
        n = ({64'd0, h} << w) | {64'd0, a};
        dv = {64'd0, b};
        nneg = 0; dneg = 0;
        if (x.opcode == OP_IDIV) begin
          if (h[w-1]) begin
            nneg = 1;
            if (w < 64) n |= ~((128'd1 << (2 * w)) - 1);
            n = -n;
          end
          if (b[w-1]) begin
            dneg = 1;
            dv = (~{64'd0, sign_ext(b, w)} + 1) & {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
          end
        end
        if (dv == 0) begin
          o.divide_error = 1'b1;
        end else begin
          q  = n / dv;
          rm = n % dv;
          if (x.opcode == OP_DIV) ok = (q <= {64'd0, m});
          else ok = (nneg != dneg) ? (q <= (128'd1 << (w - 1)))
                                   : (q < (128'd1 << (w - 1)));
          if (!ok) begin
            o.divide_error = 1'b1;
          end else begin
            if (x.opcode == OP_IDIV && nneg != dneg) q = -q;
            if (x.opcode == OP_IDIV && nneg) rm = -rm;
            o.result_lo = q[63:0] & m;
            o.result_hi = rm[63:0] & m;
            o.write_dest = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---------------- drivers ----------------
  // push stays high across back-to-back beats; it drops only for a gap or at stop_push
  task automatic send_beat(input in_t x);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= x;
    // hold the beat until an edge sees push with full low
    do @(posedge clk); while (in_full);
    sb.note_input(alu_predict(x));
    op_seen[x.opcode]++;
    n_sent++;
  endtask

  task automatic stop_push();
    in_push <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1;
      3: v = 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7) + $urandom_range(0, 1));
      default: ;
    endcase
    return v;
  endfunction

  function automatic in_t mk(input logic [3:0] op, input logic [1:0] ws,
                             input logic [63:0] a, input logic [63:0] b,
                             input logic [63:0] h);
    in_t x;
    x.opcode = op; x.width_sel = ws;
    x.operand_a = a; x.operand_b = b; x.operand_hi = h;
    return x;
  endfunction

  // Random divide with the high dividend kept small enough to avoid overflow most times.
  function automatic in_t rand_div(input logic [3:0] op);
    in_t x;
    logic [1:0] ws;
    int w;
    ws = 2'($urandom_range(0, 3));
    w = 8 << ws;
    x = mk(op, ws, rand64(), rand64(), rand64());
    if ($urandom_range(0, 3) != 0) begin
      if (op == OP_DIV) begin
        x.operand_hi = x.operand_hi % (to_width(x.operand_b, w) == 0 ? 1 : to_width(x.operand_b, w));
      end else begin
        // sign-filled high half gives a dividend that fits in w bits
        x.operand_hi = x.operand_a[w-1] ? '1 : '0;
      end
    end
    return x;
  endfunction

  // Result side: random pop stalls, beats checked at the accepting edge.
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_result(out_data);
    end
  end

  // ---------------- main sequence ----------------
  initial begin : stimulus
    in_t x;
    logic [3:0] op;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every opcode, inc/dec carry, cmp, divide faults,
    // mul overflow, undefined opcodes.
    send_beat(mk(OP_ADD,  2'd3, '1, 64'd1, '0));
    send_beat(mk(OP_ADD,  WS_8, 64'h7F, 64'h01, '0));
    send_beat(mk(OP_XADD, WS_16, 64'hFFFF, 64'hFFFF, '1));
    send_beat(mk(OP_SUB,  WS_32, 64'd0, 64'd1, '0));
    send_beat(mk(OP_CMP,  WS_8, 64'h80, 64'h01, '0));
    send_beat(mk(OP_INC,  WS_8, 64'hFF, '1, '0));
    send_beat(mk(OP_DEC,  WS_16, 64'h0, '0, '0));
    send_beat(mk(OP_NEG,  WS_32, 64'h8000_0000, '0, '0));
    send_beat(mk(OP_NEG,  2'd3, 64'd0, '0, '0));
    send_beat(mk(OP_MUL,  2'd3, '1, '1, '0));
    send_beat(mk(OP_MUL,  WS_8, 64'h0F, 64'h0F, '0));
    send_beat(mk(OP_IMULW, WS_16, 64'h8000, 64'h8000, '0));
    send_beat(mk(OP_IMULT, 2'd3, 64'h8000_0000_0000_0000, '1, '0));
    send_beat(mk(OP_IMULT, WS_8, 64'hFF, 64'hFF, '0));
    send_beat(mk(OP_MULX, 2'd3, '1, 64'd2, '0));
    send_beat(mk(OP_DIV,  WS_32, 64'd100, 64'd0, '0));
    send_beat(mk(OP_DIV,  WS_8, 64'h00, 64'h01, 64'h01));
    send_beat(mk(OP_DIV,  2'd3, '1, '1, 64'h5));
    send_beat(mk(OP_IDIV, WS_8, 64'h80, 64'hFF, 64'hFF));
    send_beat(mk(OP_IDIV, WS_16, 64'hFFF9, 64'h0002, 64'hFFFF));
    send_beat(mk(OP_IDIV, 2'd3, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000));
    send_beat(mk(4'd13, WS_8, '1, '1, '1));
    send_beat(mk(4'd15, 2'd3, '1, '1, '1));
    stop_push();

    // Hold off the sender until the pipe has fully drained once.
    wait (sb.pending.size() == 0);
    @(posedge clk);

    for (int i = 0; i < 1430; i++) begin
      op = 4'($urandom_range(0, 15));
      if (op > 12 && $urandom_range(0, 3) != 0) op = 4'($urandom_range(0, 12));
      if (op == OP_DIV || op == OP_IDIV) x = rand_div(op);
      else x = mk(op, 2'($urandom_range(0, 3)), rand64(), rand64(), rand64());
      send_beat(x);
      // occasional burst with no sender gap runs via send_beat's own zero draw
    end
    stop_push();
    sending_done = 1'b1;
  end

  initial begin : finisher
    wait (sending_done);
    wait (sb.pending.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d beats over all 16 opcode codes, %0d results checked",
             n_sent, sb.n_checked);
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule

### x86_integer_alu.f
rtl/xalu_pkg.sv
rtl/xalu_front.sv
rtl/xalu_queue.sv
rtl/xalu_back.sv
rtl/x86_integer_alu.sv
rtl/xalu_checker.sv
test/x86_integer_alu_tb.sv
